>>> rtl/core/bitmap_page_allocator_defines.svh
// Assertion macros shared by the allocator checks.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpa_checker: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define BPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpa_checker: next-cycle check failed");

// Next-cycle consequence of reset itself.
`define BPA_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("bpa_checker: post-reset check failed");

`endif

>>> rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int WORD_BITS   = 64;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int PAGE_W      = 13;
  localparam int IDX_W       = 12;
  localparam int PAGE_MAX    = 8191;
  localparam int PAGES_RESET = 4096;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  page_index;
    logic [PAGE_W-1:0] page_count;
  } bpa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] start_page;
    logic [1:0]       status;
  } bpa_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FREE_START,
    OP_FETCH,
    OP_SCAN,
    OP_MARK,
    OP_FREE,
    OP_RESULT
  } bpa_op_t;

  typedef struct packed {
    bpa_op_t    op;
    logic [1:0] res_status;
    logic       res_start;
  } bpa_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cnt_zero;
    logic       lf_ok;
    logic       idx_ok;
    logic       rsv_ok;
    logic       found;
    logic       scan_end;
    logic       word_cross;
    logic       mark_last;
    logic       free_last;
    logic       clr_last;
  } bpa_sts_t;

  // Count of zero bits below the lowest set bit; WORD_BITS when none is set.
  function automatic logic [OFF_W:0] ctz(input logic [WORD_BITS-1:0] x);
    logic [OFF_W:0] r;
    r = (OFF_W+1)'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = (OFF_W+1)'(i);
      end
    end
    return r;
  endfunction

  // Ones from bit lo up to bit hi inclusive.
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [OFF_W-1:0] lo,
                                                      input logic [OFF_W-1:0] hi);
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    a = {WORD_BITS{1'b1}} << lo;
    b = {WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - hi);
    return a & b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_FETCH_A,
    ST_SCAN,
    ST_FETCH_M,
    ST_MARK,
    ST_FETCH_F,
    ST_FREE,
    ST_DONE
  } state_t;

  state_t     state;
  logic [1:0] res_status;
  logic       res_start;
  logic       rsp_free;

  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd.res_status = res_status;
    cmd.res_start  = res_start;
    unique case (state)
      ST_CLEAR:   cmd.op = OP_CLEAR;
      ST_IDLE:    cmd.op = req_valid ? OP_LOAD : OP_NONE;
      ST_DECIDE:  cmd.op = (sts.mode == MODE_FREE && sts.idx_ok) ? OP_FREE_START : OP_NONE;
      ST_FETCH_A: cmd.op = OP_FETCH;
      ST_SCAN:    cmd.op = OP_SCAN;
      ST_FETCH_M: cmd.op = OP_FETCH;
      ST_MARK:    cmd.op = OP_MARK;
      ST_FETCH_F: cmd.op = OP_FETCH;
      ST_FREE:    cmd.op = OP_FREE;
      ST_DONE:    cmd.op = rsp_free ? OP_RESULT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      rsp_valid  <= 1'b0;
      res_status <= STATUS_OK;
      res_start  <= 1'b0;
    end else begin
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (sts.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            res_status <= STATUS_OK;
            res_start  <= 1'b0;
            state      <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          unique case (sts.mode)
            MODE_ALLOC: begin
              if (sts.cnt_zero || !sts.lf_ok) begin
                res_status <= STATUS_NO_SPACE;
                state      <= ST_DONE;
              end else begin
                state <= ST_FETCH_A;
              end
            end
            MODE_FREE: begin
              if (!sts.idx_ok) begin
                res_status <= STATUS_RANGE;
                state      <= ST_DONE;
              end else begin
                state <= ST_FETCH_F;
              end
            end
            MODE_RESERVE: begin
              if (!sts.rsv_ok) begin
                res_status <= STATUS_RANGE;
                state      <= ST_DONE;
              end else if (sts.cnt_zero) begin
                state <= ST_DONE;
              end else begin
                state <= ST_FETCH_M;
              end
            end
            default: begin
              res_status <= STATUS_RANGE;
              state      <= ST_DONE;
            end
          endcase
        end
        ST_FETCH_A: state <= ST_SCAN;
        ST_SCAN: begin
          if (sts.found) begin
            res_start <= 1'b1;
            state     <= ST_FETCH_M;
          end else if (sts.scan_end) begin
            res_status <= STATUS_NO_SPACE;
            state      <= ST_DONE;
          end else if (sts.word_cross) begin
            state <= ST_FETCH_A;
          end
        end
        ST_FETCH_M: state <= ST_MARK;
        ST_MARK: begin
          state <= sts.mark_last ? ST_DONE : ST_FETCH_M;
        end
        ST_FETCH_F: state <= ST_FREE;
        ST_FREE: begin
          state <= sts.free_last ? ST_DONE : ST_FETCH_F;
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bpa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bpa_dpath #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bpa_pkg::bpa_cmd_t         cmd,
  output bpa_pkg::bpa_sts_t         sts,
  input  bpa_pkg::bpa_req_t         req,
  input  logic                      cfg_we,
  input  logic [bpa_pkg::PAGE_W-1:0] cfg_wdata,
  output bpa_pkg::bpa_rsp_t         rsp
);
  import bpa_pkg::*;

  // Pages past the 13-bit register range can never be addressed.
  localparam int CAP   = (MAX_PAGES < PAGE_MAX) ? MAX_PAGES : PAGE_MAX;
  localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [PAGE_W-1:0] CAP_V = PAGE_W'(CAP);

  logic [WORD_BITS-1:0] res_mem  [WORDS];
  logic [WORD_BITS-1:0] cont_mem [WORDS];
  logic [WORD_BITS-1:0] res_rd;
  logic [WORD_BITS-1:0] cont_rd;
  logic [WORD_BITS-1:0] res_wr;
  logic [WORD_BITS-1:0] cont_wr;
  logic                 mem_we;
  logic [WAW-1:0]       maddr;
  logic [WAW-1:0]       clr_addr;

  logic [PAGE_W-1:0] pages;
  logic [PAGE_W-1:0] total;
  logic [IDX_W-1:0]  last_freed;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  idx;
  logic [PAGE_W-1:0] cnt;
  logic [PAGE_W-1:0] p;
  logic [PAGE_W-1:0] run;
  logic [PAGE_W-1:0] run_start;
  logic [PAGE_W-1:0] m_end;

  logic [OFF_W-1:0]  off;
  logic [PAGE_W:0]   wbase;
  logic [PAGE_W:0]   word_end;
  logic [OFF_W:0]    room;

  // Scan of one uniform segment of the reserved word.
  logic [WORD_BITS-1:0] s_sh;
  logic [WORD_BITS-1:0] s_y;
  logic                 s_bit;
  logic [OFF_W:0]       s_len;
  logic [OFF_W:0]       seg_w;
  logic [PAGE_W-1:0]    remain;
  logic [PAGE_W-1:0]    seg;
  logic [PAGE_W-1:0]    p_scan;
  logic [PAGE_W:0]      run_sum;
  logic                 found;

  // Marking of a run within one word.
  logic [PAGE_W:0]      rel;
  logic                 mark_last;
  logic [OFF_W-1:0]     hi_off;
  logic [WORD_BITS-1:0] m_mask;
  logic [WORD_BITS-1:0] last_mask;

  // Free walk within one word.
  logic [OFF_W:0]       e_len;
  logic                 stop_in;
  logic [OFF_W-1:0]     stop_off;
  logic [PAGE_W:0]      lim;
  logic                 lim_in;
  logic [OFF_W-1:0]     lim_off;
  logic [OFF_W-1:0]     end_off;
  logic [WORD_BITS-1:0] f_mask;

  assign total    = (pages > CAP_V) ? CAP_V : pages;
  assign off      = p[OFF_W-1:0];
  assign wbase    = {1'b0, p[PAGE_W-1:OFF_W], {OFF_W{1'b0}}};
  assign word_end = wbase + (PAGE_W+1)'(WORD_BITS);
  assign room     = (OFF_W+1)'(WORD_BITS) - {1'b0, off};

  assign s_sh    = res_rd >> off;
  assign s_bit   = s_sh[0];
  assign s_y     = s_bit ? ~s_sh : s_sh;
  assign s_len   = ctz(s_y);
  assign seg_w   = (s_len < room) ? s_len : room;
  assign remain  = total - p;
  assign seg     = (PAGE_W'(seg_w) < remain) ? PAGE_W'(seg_w) : remain;
  assign p_scan  = p + seg;
  assign run_sum = {1'b0, run} + {1'b0, seg};
  assign found   = !s_bit && (run_sum >= {1'b0, cnt});

  assign rel       = {1'b0, m_end} - wbase;
  assign mark_last = rel <= (PAGE_W+1)'(WORD_BITS);
  assign hi_off    = mark_last ? OFF_W'(rel - (PAGE_W+1)'(1)) : {OFF_W{1'b1}};
  assign m_mask    = range_mask(off, hi_off);
  assign last_mask = mark_last ? (WORD_BITS'(1) << hi_off) : '0;

  assign e_len    = ctz(~cont_rd >> off);
  assign stop_in  = e_len < room;
  assign stop_off = OFF_W'({1'b0, off} + e_len);
  assign lim      = {1'b0, total} - (PAGE_W+1)'(1);
  assign lim_in   = lim < word_end;
  assign lim_off  = OFF_W'(lim - wbase);
  assign f_mask   = range_mask(off, end_off);

  // The walk ends at whichever comes first: a clear continuation bit,
  // the last page of the region, or the end of the word.
  always_comb begin
    end_off = {OFF_W{1'b1}};
    if (lim_in && lim_off < end_off) begin
      end_off = lim_off;
    end
    if (stop_in && stop_off < end_off) begin
      end_off = stop_off;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    res_wr  = '0;
    cont_wr = '0;
    maddr   = WAW'(p >> OFF_W);
    case (cmd.op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        maddr  = clr_addr;
      end
      OP_MARK: begin
        mem_we  = 1'b1;
        res_wr  = res_rd | m_mask;
        cont_wr = (cont_rd & ~m_mask) | (m_mask & ~last_mask);
      end
      OP_FREE: begin
        mem_we  = 1'b1;
        res_wr  = res_rd & ~f_mask;
        cont_wr = cont_rd;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_mem[maddr]  <= res_wr;
      cont_mem[maddr] <= cont_wr;
    end
    if (cmd.op == OP_FETCH) begin
      res_rd  <= res_mem[maddr];
      cont_rd <= cont_mem[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      last_freed <= '0;
      pages      <= PAGE_W'(PAGES_RESET);
    end else begin
      if (cfg_we) begin
        pages <= cfg_wdata;
      end
      case (cmd.op)
        OP_CLEAR: clr_addr <= clr_addr + WAW'(1);
        OP_LOAD: begin
          mode      <= req.mode;
          idx       <= req.page_index;
          cnt       <= req.page_count;
          run       <= '0;
          m_end     <= {1'b0, req.page_index} + req.page_count;
          if (req.mode == MODE_ALLOC) begin
            p         <= {1'b0, last_freed};
            run_start <= {1'b0, last_freed};
          end else begin
            p         <= {1'b0, req.page_index};
            run_start <= {1'b0, req.page_index};
          end
        end
        OP_FREE_START: last_freed <= idx;
        OP_SCAN: begin
          if (found) begin
            p     <= run_start;
            m_end <= run_start + cnt;
          end else if (s_bit) begin
            p         <= p_scan;
            run       <= '0;
            run_start <= p_scan;
          end else begin
            p   <= p_scan;
            run <= PAGE_W'(run_sum);
          end
        end
        OP_MARK, OP_FREE: p <= PAGE_W'(word_end);
        OP_RESULT: begin
          rsp.start_page <= cmd.res_start ? run_start[IDX_W-1:0] : '0;
          rsp.status     <= cmd.res_status;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.mode       = mode;
    sts.cnt_zero   = (cnt == '0);
    sts.lf_ok      = p < total;
    sts.idx_ok     = {1'b0, idx} < total;
    sts.rsv_ok     = ({2'b0, idx} + {1'b0, cnt}) < {1'b0, total};
    sts.found      = found;
    sts.scan_end   = p_scan >= total;
    sts.word_cross = (p_scan[OFF_W-1:0] == '0);
    sts.mark_last  = mark_last;
    sts.free_last  = stop_in || lim_in;
    sts.clr_last   = (clr_addr == WAW'(WORDS - 1));
  end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_page_allocator.sv
// One request at a time. Allocate: decide; per bitmap word visited, a fetch and a scan
// step per free/used segment; a fetch and a mark per run word; post the response.
// Free and reserve: decide, a fetch and write-back per word touched, then post. The
// single-port 64-bit bitmap words are read, then written back. After reset a clearing
// pass writes one word a cycle to all ceil(min(MAX_PAGES, 8191)/64) words (64 at the
// default) with requests stalled; config writes are taken anytime.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bpa_pkg::bpa_req_t          req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bpa_pkg::bpa_rsp_t          rsp,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::PAGE_W-1:0] cfg_wdata
);
  import bpa_pkg::*;

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/core/bpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input bpa_pkg::bpa_rsp_t rsp
);
  import bpa_pkg::*;

  // A stalled response holds.
  `BPA_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Only one request is in flight: a transfer makes the block busy next cycle.
  `BPA_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)

  // The bitmap clearing pass keeps requests out right after reset.
  `BPA_ASSERT_RST(a_clear_after_rst, req_stall)

  // Failed requests report no start page.
  `BPA_ASSERT_IMP(a_fail_start_zero, rsp_valid && rsp.status != STATUS_OK,
                  rsp.start_page == '0)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire
